[hw/rtl/percent_escape_decoder_assert.svh]
// Assertion macros for the percent-escape decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PERCENT_ESCAPE_DECODER_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PED_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("percent_escape_decoder: same-cycle check failed");
`define PED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("percent_escape_decoder: next-cycle check failed");
`else
`define PED_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/ped_pkg.sv]
// Shared types, constants and hex helpers for the percent-escape decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package ped_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Pending-escape codes held by the front end
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One request's worth of decoded bytes, cnt in 1..3, data[0] goes out first
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
        logic            last;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qhead;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Only meaningful when is_hex(b) holds
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = 4'(b[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ped_front.sv]
// Front end: accepts raw bytes, tracks the pending escape, emits queue entries.
// Depends on ped_pkg.
`default_nettype none
module ped_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_last,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output ped_pkg::t_entry      o_entry
);

    logic [1:0]      r_pend;
    logic [1:0]      n_pend;
    logic [7:0]      r_held;
    logic [7:0]      n_held;
    logic [1:0]      c_cnt;
    logic [2:0][7:0] c_data;
    logic            c_accept;

    assign o_in_ready = !i_q_full;
    assign c_accept   = i_in_valid && o_in_ready;

    always_comb begin
        logic do_fresh;
        c_cnt    = '0;
        c_data   = '0;
        n_pend   = r_pend;
        n_held   = r_held;
        do_fresh = 1'b0;

        unique case (r_pend)
            ped_pkg::PEND_PCT: begin
                if (ped_pkg::is_hex(i_in_byte)) begin
                    n_pend = ped_pkg::PEND_DIGIT;
                    n_held = i_in_byte;
                end else begin
                    c_data[0] = ped_pkg::PCT_CHAR;
                    c_cnt     = 2'd1;
                    n_pend    = ped_pkg::PEND_NONE;
                    do_fresh  = 1'b1;
                end
            end
            ped_pkg::PEND_DIGIT: begin
                if (ped_pkg::is_hex(i_in_byte)) begin
                    c_data[0] = {ped_pkg::hex_val(r_held), ped_pkg::hex_val(i_in_byte)};
                    c_cnt     = 2'd1;
                end else begin
                    c_data[0] = ped_pkg::PCT_CHAR;
                    c_data[1] = r_held;
                    c_cnt     = 2'd2;
                    do_fresh  = 1'b1;
                end
                n_pend = ped_pkg::PEND_NONE;
            end
            default: begin
                n_pend   = ped_pkg::PEND_NONE;
                do_fresh = 1'b1;
            end
        endcase

        // Re-examine the byte as a fresh one
        if (do_fresh) begin
            if (i_in_byte == ped_pkg::PCT_CHAR) begin
                n_pend = ped_pkg::PEND_PCT;
            end else begin
                c_data[c_cnt] = i_in_byte;
                c_cnt         = c_cnt + 2'd1;
            end
        end

        // Flush anything still pending at end of string
        if (i_in_last) begin
            if (n_pend == ped_pkg::PEND_PCT) begin
                c_data[c_cnt] = ped_pkg::PCT_CHAR;
                c_cnt         = c_cnt + 2'd1;
            end else if (n_pend == ped_pkg::PEND_DIGIT) begin
                c_data[0] = ped_pkg::PCT_CHAR;
                c_data[1] = n_held;
                c_cnt     = 2'd2;
            end
            n_pend = ped_pkg::PEND_NONE;
        end
    end

    assign o_push        = c_accept && (c_cnt != 2'd0);
    assign o_entry.cnt   = c_cnt;
    assign o_entry.data  = c_data;
    assign o_entry.last  = i_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= ped_pkg::PEND_NONE;
        end else if (c_accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_held <= n_held;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ped_queue.sv]
// Short entry queue between front and back end of the decoder.
// Depends on ped_pkg.
`default_nettype none
module ped_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ped_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output ped_pkg::t_qhead      o_head
);

    ped_pkg::t_entry                r_mem [ped_pkg::QDEPTH];
    logic [ped_pkg::QAW-1:0]        r_wptr;
    logic [ped_pkg::QAW-1:0]        r_rptr;
    logic [ped_pkg::QCW-1:0]        r_cnt;

    function automatic logic [ped_pkg::QAW-1:0] ptr_inc(input logic [ped_pkg::QAW-1:0] p);
        return (p == ped_pkg::QAW'(ped_pkg::QDEPTH - 1)) ? '0 : p + ped_pkg::QAW'(1);
    endfunction

    assign o_full       = (r_cnt == ped_pkg::QCW'(ped_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + ped_pkg::QCW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - ped_pkg::QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ped_back.sv]
// Back end: walks each queued entry byte by byte into the output register.
// Depends on ped_pkg.
`default_nettype none
module ped_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ped_pkg::t_qhead i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [1:0] r_idx;
    logic       c_free;
    logic       c_take;
    logic       c_final;

    assign c_free  = !r_out_valid || i_out_ready;
    assign c_take  = i_head.valid && c_free;
    assign c_final = (r_idx == (i_head.entry.cnt - 2'd1));
    assign o_pop   = c_take && c_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (c_free) begin
                r_out_valid <= c_take;
            end
            if (c_take) begin
                r_idx <= c_final ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_out_byte <= i_head.entry.data[r_idx];
            r_out_last <= i_head.entry.last && c_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

[hw/rtl/percent_escape_decoder.sv]
// Streaming URI percent-decoder, top level.
// Depends on ped_pkg, ped_front, ped_queue, ped_back and the assertion header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one raw byte per request,
//   with i_in_last on the final byte of a string. Output channel
//   (o_out_valid / i_out_ready) carries decoded bytes; o_out_last marks the
//   final decoded byte of a string. A string's last input always yields at
//   least one output, so every string ends with o_out_last.
//   "%XY" with two hex digits becomes one byte; a broken escape passes the
//   '%' (and any held digit) through as text and rescans the offending byte.
//   Anything pending at the last byte is flushed as text.
// Timing:
//   An accepted request is written into the queue; the back end then moves
//   its bytes one by one into the output register, which holds each until
//   i_out_ready. One input request is taken every cycle while the queue is
//   not full; the back end drains one output byte per cycle while the
//   receiver is ready, so broken escapes that expand to two or three bytes
//   build up in the 4-entry queue; o_in_ready drops only when it is full.
// Reset: synchronous, active low; clears the pending escape, the queue and
//   the output register. When the receiver stalls, the output register holds
//   and the queue fills, after which input is back-pressured.
`default_nettype none
`include "percent_escape_decoder_assert.svh"
module percent_escape_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    ped_pkg::t_entry    q_entry;
    ped_pkg::t_qhead    q_head;
    logic               in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // Classify bytes and hold the pending escape
    ped_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (q_entry)
    );

    // Decouple the two sides
    ped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Serialize entries to the output register
    ped_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    // End of string must always enqueue something carrying the last flag
    `PED_ASSERT_IMPLY(a_last_pushes, i_clk, i_rst_n, in_acc && i_in_last, q_push && q_entry.last)
    // Queued entries are never empty, or the back end would stall on them
    `PED_ASSERT_IMPLY(a_head_nonempty, i_clk, i_rst_n, q_head.valid, q_head.entry.cnt != 2'd0)

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for percent_escape_decoder: directed escapes, then random strings.
// Depends on ped_pkg and the percent_escape_decoder RTL; nothing else.
`timescale 1ns / 100ps

typedef logic [7:0] t_byte_q[$];

typedef struct packed {
    logic [7:0] data;
    logic       last;
} t_dec_byte;

// Hex digit value of a character, or -1 when it is not a hex digit
function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
endfunction

class decode_scoreboard;
    logic [1:0] pend;
    logic [7:0] held_char;
    t_dec_byte  decoded_q[$];
    int         errors;
    int         checked;
    int         lasts_seen;
    int         triples;

    function new();
        pend       = ped_pkg::PEND_NONE;
        held_char  = 8'h00;
        errors     = 0;
        checked    = 0;
        lasts_seen = 0;
        triples    = 0;
    endfunction

    // Plain scan of a byte with nothing pending
    function void scan_plain(input logic [7:0] b, ref logic [7:0] outs[$]);
        if (b == ped_pkg::PCT_CHAR) begin
            pend = ped_pkg::PEND_PCT;
        end else begin
            outs.push_back(b);
        end
    endfunction

    // Decode one accepted request and queue the bytes it must produce
    function void decode_request(input logic [7:0] b, input logic last);
        logic [7:0] outs[$];
        int         lo;
        t_dec_byte  d;
        lo = hex_nibble(b);
        case (pend)
            ped_pkg::PEND_PCT: begin
                if (lo >= 0) begin
                    held_char = b;
                    pend      = ped_pkg::PEND_DIGIT;
                end else begin
                    outs.push_back(ped_pkg::PCT_CHAR);
                    pend = ped_pkg::PEND_NONE;
                    scan_plain(b, outs);
                end
            end
            ped_pkg::PEND_DIGIT: begin
                if (lo >= 0) begin
                    outs.push_back({4'(hex_nibble(held_char)), lo[3:0]});
                    pend = ped_pkg::PEND_NONE;
                end else begin
                    outs.push_back(ped_pkg::PCT_CHAR);
                    outs.push_back(held_char);
                    pend = ped_pkg::PEND_NONE;
                    scan_plain(b, outs);
                end
            end
            default: begin
                pend = ped_pkg::PEND_NONE;
                scan_plain(b, outs);
            end
        endcase
        if (last) begin
            if (pend == ped_pkg::PEND_PCT) begin
                outs.push_back(ped_pkg::PCT_CHAR);
            end else if (pend == ped_pkg::PEND_DIGIT) begin
                outs.push_back(ped_pkg::PCT_CHAR);
                outs.push_back(held_char);
            end
            pend = ped_pkg::PEND_NONE;
        end
        if (outs.size() == 3) triples++;
        foreach (outs[i]) begin
            d.data = outs[i];
            d.last = last && (i == outs.size() - 1);
            decoded_q.push_back(d);
        end
    endfunction

    function void check_byte(input logic [7:0] data, input logic last);
        t_dec_byte d;
        if (decoded_q.size() == 0) begin
            $display("%0t: unexpected output byte 8'h%02h last=%0b", $time, data, last);
            errors++;
            return;
        end
        d = decoded_q.pop_front();
        checked++;
        if (last) lasts_seen++;
        if (data !== d.data) begin
            $display("%0t: out_byte mismatch, expected 8'h%02h, got 8'h%02h",
                     $time, d.data, data);
            errors++;
        end
        if (last !== d.last) begin
            $display("%0t: out_last mismatch, expected %0b, got %0b", $time, d.last, last);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int HALF_PERIOD  = 10;
    localparam int MAX_GAP      = 12;
    localparam int TOTAL_ITEMS  = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    decode_scoreboard sb;

    // Idle knobs, changed between strings so some stretches run back to back
    bit tx_idle;
    bit rx_idle;
    // Set once by the stimulus; the receiver counts the hold itself
    bit long_hold;

    int requests_sent;
    int strings_sent;
    int cycles;

    percent_escape_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: bail out if the run hangs anywhere
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycles, sb.decoded_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] pick_hex();
        logic [7:0] digits[22];
        digits = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                   "a", "b", "c", "d", "e", "f", "A", "B", "C", "D", "E", "F"};
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Offer one request; hold valid and payload until the block takes it
    task automatic send_req(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.decode_request(b, last);
        requests_sent++;
    endtask

    // Send a whole string, marking only its final byte as last when last_on_end is set
    task automatic send_string(input t_byte_q s, input logic last_on_end);
        foreach (s[i]) send_req(s[i], last_on_end && (i == s.size() - 1));
        strings_sent++;
    endtask

    // Receiver: stall at random, absorb the one long hold, check every byte
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_byte(o_out_byte, o_out_last);
        end
    end

    initial begin
        t_byte_q str;
        int      pick;
        int      len;

        sb            = new();
        cycles        = 0;
        requests_sent = 0;
        strings_sent  = 0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        long_hold     = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = 8'h00;
        i_in_last     = 1'b0;
        i_out_ready   = 1'b0;

        // Hold reset, release on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: good escape with upper and lower case digits
        str = '{ped_pkg::PCT_CHAR, "4", "1"};
        send_string(str, 1'b0);
        str = '{ped_pkg::PCT_CHAR, "f", "F"};
        send_string(str, 1'b1);
        // Broken right after the percent: pass it through, rescan the byte
        str = '{ped_pkg::PCT_CHAR, "g"};
        send_string(str, 1'b0);
        // Broken after one digit: three bytes out of one request
        str = '{ped_pkg::PCT_CHAR, "4", "z"};
        send_string(str, 1'b0);
        // A second percent restarts the escape
        str = '{ped_pkg::PCT_CHAR, ped_pkg::PCT_CHAR, "3", "0"};
        send_string(str, 1'b0);
        // Byte extremes, the top one closing a string
        str = '{8'h00, 8'hFF};
        send_string(str, 1'b1);
        // End of string flushes a lone percent, then a percent with one digit
        str = '{ped_pkg::PCT_CHAR};
        send_string(str, 1'b1);
        str = '{ped_pkg::PCT_CHAR, "a"};
        send_string(str, 1'b1);
        // Broken escape leaving a new one pending, flushed at the end
        str = '{ped_pkg::PCT_CHAR, "9", ped_pkg::PCT_CHAR, "0"};
        send_string(str, 1'b1);

        // Random part: mostly well-formed escapes and text, some broken escapes
        while (requests_sent < TOTAL_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            str     = {};
            len     = $urandom_range(1, 8);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    str.push_back(8'($urandom_range(0, 255)) == ped_pkg::PCT_CHAR ?
                                  8'h26 : 8'($urandom_range(0, 255)));
                end else if (pick < 75) begin
                    str.push_back(ped_pkg::PCT_CHAR);
                    str.push_back(pick_hex());
                    str.push_back(pick_hex());
                end else if (pick < 83) begin
                    str.push_back(ped_pkg::PCT_CHAR);
                    str.push_back(pick_non_hex());
                end else if (pick < 91) begin
                    str.push_back(ped_pkg::PCT_CHAR);
                    str.push_back(pick_hex());
                    str.push_back(pick_non_hex());
                end else if (pick < 95) begin
                    // Truncated escape, often at the end of the string
                    str.push_back(ped_pkg::PCT_CHAR);
                    if (pick[0]) str.push_back(pick_hex());
                end else begin
                    str.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_string(str, ($urandom_range(0, 3) != 0));

            // Once, midway: stop the receiver and keep offering back to back
            if (strings_sent == 40) begin
                long_hold = 1'b1;
                tx_idle   = 1'b0;
                str       = {};
                repeat (12) begin
                    str.push_back(ped_pkg::PCT_CHAR);
                    str.push_back(pick_hex());
                    str.push_back(pick_non_hex());
                end
                send_string(str, 1'b1);
            end
        end

        // Drop valid, then drain whatever is still owed
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests in %0d strings; %0d decoded bytes checked,",
                 requests_sent, strings_sent, sb.checked);
        $display("%0d string ends, %0d three-byte expansions, %0d errors.",
                 sb.lasts_seen, sb.triples, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ped_pkg.sv
hw/rtl/ped_front.sv
hw/rtl/ped_queue.sv
hw/rtl/ped_back.sv
hw/rtl/percent_escape_decoder.sv
tb/tb.sv
